// ----- hdl/rgb_to_nv12_converter_assert.svh -----
// ----------------------------------------------------------------------------
// RGB to NV12 converter assertion macros
// Concurrent assertion wrappers clocked on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_NV12_CONVERTER_ASSERT_SVH
`define RGB_TO_NV12_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define R2N_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define R2N_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define R2N_ASSERT_SAME(label, ante, cons)
`define R2N_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/r2n_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to NV12 converter package
// Shared sizes, register indexes, coefficients and flag struct.
// ----------------------------------------------------------------------------
package r2n_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W = 13;
  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] SIZE_MASK          = 13'h1FFE;
  localparam logic [CFG_W-1:0] SIZE_MIN           = 13'd2;

  // luma coefficients, Q10
  localparam int Y_R = 306;
  localparam int Y_G = 601;
  localparam int Y_B = 117;
  localparam int Y_SHIFT = 10;

  // chroma coefficients, Q8
  localparam int U_R = 38;
  localparam int U_G = 74;
  localparam int U_B = 112;
  localparam int V_R = 112;
  localparam int V_G = 94;
  localparam int V_B = 18;
  localparam int C_ROUND = 128;
  localparam int C_SHIFT = 8;

  typedef struct packed {
    logic chroma;
    logic line_end;
    logic frame_end;
  } pos_flags_t;

endpackage

// ----- hdl/r2n_position.sv -----
// ----------------------------------------------------------------------------
// RGB to NV12 converter position tracker
// Holds the size registers and the column/row counters, flags each item.
// ----------------------------------------------------------------------------
`include "rgb_to_nv12_converter_assert.svh"

module r2n_position (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [r2n_pkg::IDX_W-1:0]       cfg_index,
  input  logic [r2n_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            advance,
  output r2n_pkg::pos_flags_t             flags
);

  logic [r2n_pkg::CFG_W-1:0] line_width;
  logic [r2n_pkg::CFG_W-1:0] frame_height;
  logic [r2n_pkg::CNT_W-1:0] col;
  logic [r2n_pkg::ROW_W-1:0] row;

  logic [r2n_pkg::CFG_W-1:0] eff_w;
  logic [r2n_pkg::CFG_W-1:0] eff_h;
  logic [r2n_pkg::CFG_W-1:0] last_col;
  logic [r2n_pkg::CFG_W-1:0] last_row;

  function automatic logic [r2n_pkg::CFG_W-1:0] clamp_size(
    input logic [r2n_pkg::CFG_W-1:0] value,
    input logic [r2n_pkg::CFG_W-1:0] max_size
  );
    logic [r2n_pkg::CFG_W-1:0] s;
    s = value & r2n_pkg::SIZE_MASK;
    if (s < r2n_pkg::SIZE_MIN) s = r2n_pkg::SIZE_MIN;
    if (s > max_size) s = max_size;
    return s;
  endfunction

  always_comb begin
    eff_w    = clamp_size(line_width, r2n_pkg::CFG_W'(r2n_pkg::MAX_WIDTH));
    eff_h    = clamp_size(frame_height, r2n_pkg::CFG_W'(r2n_pkg::MAX_HEIGHT));
    last_col = eff_w - r2n_pkg::CFG_W'(1);
    last_row = eff_h - r2n_pkg::CFG_W'(1);
    flags.chroma    = ~col[0] & ~row[0];
    flags.line_end  = r2n_pkg::CFG_W'(col) >= last_col;
    flags.frame_end = flags.line_end && (r2n_pkg::CFG_W'(row) >= last_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= r2n_pkg::LINE_WIDTH_RESET;
      frame_height <= r2n_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        r2n_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data;
        r2n_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (flags.line_end) begin
        col <= '0;
        row <= flags.frame_end ? '0 : row + r2n_pkg::ROW_W'(1);
      end else begin
        col <= col + r2n_pkg::CNT_W'(1);
      end
    end
  end

  `R2N_ASSERT_NEXT(a_line_wrap, advance && flags.line_end, col == '0)
  `R2N_ASSERT_NEXT(a_chroma_pair, advance && flags.chroma, col[0] || col == '0)

endmodule

// ----- hdl/r2n_color_math.sv -----
// ----------------------------------------------------------------------------
// RGB to NV12 converter color math
// Constant-coefficient luma and point-sampled chroma for one pixel.
// ----------------------------------------------------------------------------
module r2n_color_math (
  input  logic       [7:0] blue,
  input  logic       [7:0] green,
  input  logic       [7:0] red,
  input  logic             chroma_en,
  output logic       [7:0] luma,
  output logic       [7:0] chroma_u,
  output logic       [7:0] chroma_v
);

  logic        [17:0] y_sum;
  logic signed [17:0] r_s;
  logic signed [17:0] g_s;
  logic signed [17:0] b_s;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  logic        [17:0] u_bias;
  logic        [17:0] v_bias;

  always_comb begin
    y_sum = 18'(r2n_pkg::Y_R) * {10'd0, red} + 18'(r2n_pkg::Y_G) * {10'd0, green}
          + 18'(r2n_pkg::Y_B) * {10'd0, blue};
    luma  = y_sum[r2n_pkg::Y_SHIFT +: 8];

    r_s = signed'({10'd0, red});
    g_s = signed'({10'd0, green});
    b_s = signed'({10'd0, blue});
    u_sum = signed'(18'(r2n_pkg::C_ROUND)) - signed'(18'(r2n_pkg::U_R)) * r_s
          - signed'(18'(r2n_pkg::U_G)) * g_s + signed'(18'(r2n_pkg::U_B)) * b_s;
    v_sum = signed'(18'(r2n_pkg::C_ROUND)) + signed'(18'(r2n_pkg::V_R)) * r_s
          - signed'(18'(r2n_pkg::V_G)) * g_s - signed'(18'(r2n_pkg::V_B)) * b_s;
    // floor shift plus 128 offset: bias by 32768 and take the byte
    u_bias = unsigned'(u_sum) + 18'd32768;
    v_bias = unsigned'(v_sum) + 18'd32768;
    chroma_u = chroma_en ? u_bias[r2n_pkg::C_SHIFT +: 8] : 8'd0;
    chroma_v = chroma_en ? v_bias[r2n_pkg::C_SHIFT +: 8] : 8'd0;
  end

endmodule

// ----- hdl/rgb_to_nv12_converter.sv -----
// ----------------------------------------------------------------------------
// RGB to NV12 converter
// Datapath: each item passes through the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls; each stage loads when empty or when the next frees.
// Reset: synchronous rst empties both stages, clears the column and row
// counters and loads line_width 640 and frame_height 480.
// ----------------------------------------------------------------------------
`include "rgb_to_nv12_converter_assert.svh"

module rgb_to_nv12_converter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [r2n_pkg::IDX_W-1:0]   cfg_index,
  input  logic [r2n_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  blue,
  input  logic [7:0]                  green,
  input  logic [7:0]                  red,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  luma,
  output logic                        chroma_valid,
  output logic [7:0]                  chroma_u,
  output logic [7:0]                  chroma_v,
  output logic                        line_end,
  output logic                        frame_end
);

  logic                s1_valid;
  logic [7:0]          s1_blue;
  logic [7:0]          s1_green;
  logic [7:0]          s1_red;
  r2n_pkg::pos_flags_t s1_flags;
  r2n_pkg::pos_flags_t pos_flags;

  logic       out_free;
  logic       accept;
  logic [7:0] luma_next;
  logic [7:0] chroma_u_next;
  logic [7:0] chroma_v_next;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  assign accept   = in_valid && in_ready;

  r2n_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .flags     (pos_flags)
  );

  r2n_color_math u_color_math (
    .blue      (s1_blue),
    .green     (s1_green),
    .red       (s1_red),
    .chroma_en (s1_flags.chroma),
    .luma      (luma_next),
    .chroma_u  (chroma_u_next),
    .chroma_v  (chroma_v_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blue  <= blue;
      s1_green <= green;
      s1_red   <= red;
      s1_flags <= pos_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      luma         <= luma_next;
      chroma_valid <= s1_flags.chroma;
      chroma_u     <= chroma_u_next;
      chroma_v     <= chroma_v_next;
      line_end     <= s1_flags.line_end;
      frame_end    <= s1_flags.frame_end;
    end
  end

  `R2N_ASSERT_NEXT(a_s1_held, s1_valid && !out_free, s1_valid)
  `R2N_ASSERT_SAME(a_frame_in_line, out_valid && frame_end, line_end)

endmodule
